// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the core RTL sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define LCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define LCT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LCT_ASSERT(lbl, prop, msg)
`define LCT_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lct_pkg.sv =====
package lct_pkg;

    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  value;
        logic [15:0] cost;
    } t_rec;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_APPEND = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    localparam logic [2:0] KIND_LOOKUP_KEY   = 3'd0;
    localparam logic [2:0] KIND_LOOKUP_VALUE = 3'd1;
    localparam logic [2:0] KIND_UPSERT_ZERO  = 3'd2;
    localparam logic [2:0] KIND_UPSERT_COST  = 3'd3;
    localparam logic [2:0] KIND_DELETE       = 3'd4;

    localparam logic [7:0]  KEY_NONE   = 8'hFF;
    localparam logic [7:0]  VALUE_NONE = 8'hFF;
    localparam logic [15:0] COST_NONE  = 16'hFFFF;

endpackage

// ===== rtl/core/lct_mem.sv =====
module lct_mem #(
    parameter int ENTRIES = 32,
    parameter int AW      = 5
) (
    input  logic                i_clk,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  lct_pkg::t_rec       i_wdata,
    output lct_pkg::t_rec       o_rdata
);

    lct_pkg::t_rec r_mem [ENTRIES];
    lct_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lct_seq.sv =====
`include "assert_macros.svh"

module lct_seq #(
    parameter int ENTRIES = 32,
    parameter int AW      = 5,
    parameter int CW      = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_entry_key,
    input  logic [7:0]          i_entry_value,
    input  logic [15:0]         i_entry_cost,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [7:0]          o_out_key,
    output logic [7:0]          o_out_value,
    output logic [15:0]         o_out_cost,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output lct_pkg::t_rec       o_mem_wdata,
    input  lct_pkg::t_rec       i_mem_rdata
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic [2:0]       r_kind;
    logic [7:0]       r_key;
    logic [7:0]       r_value;
    logic [15:0]      r_cost;
    logic [CW-1:0]    r_rd;
    logic             r_vld;
    logic [AW-1:0]    r_idx;
    logic             r_shift;
    logic [CW-1:0]    r_count;
    logic             r_ovld;
    lct_pkg::t_status r_status;
    logic [7:0]       r_okey;
    logic [7:0]       r_ovalue;
    logic [15:0]      r_ocost;

    logic scanning;
    logic issue;
    logic match;
    logic hit;
    logic scan_end;
    logic full;
    logic upsert;

    assign scanning = (r_state == S_SCAN);
    assign issue    = scanning && (r_rd < r_count);
    assign match    = (r_kind == lct_pkg::KIND_LOOKUP_VALUE) ? (i_mem_rdata.value == r_value)
                                                             : (i_mem_rdata.key == r_key);
    assign hit      = scanning && r_vld && match && !r_shift;
    assign scan_end = scanning && !r_vld && !issue;
    assign full     = (r_count == CW'(ENTRIES));
    assign upsert   = (r_kind == lct_pkg::KIND_UPSERT_ZERO) ||
                      (r_kind == lct_pkg::KIND_UPSERT_COST);

    assign o_mem_re    = issue;
    assign o_mem_raddr = r_rd[AW-1:0];

    // Reads run one entry ahead of writes, so a write never hits the entry being read.
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        if (scanning && r_shift && r_vld) begin
            // close the gap: move each later record down one slot
            o_mem_we    = 1'b1;
            o_mem_waddr = r_idx - 1'b1;
        end else if (hit && upsert) begin
            o_mem_we          = 1'b1;
            o_mem_wdata.value = r_value;
            o_mem_wdata.cost  = r_cost;
        end else if (scan_end && !r_shift && upsert && !full) begin
            o_mem_we          = 1'b1;
            o_mem_waddr       = r_count[AW-1:0];
            o_mem_wdata.key   = r_key;
            o_mem_wdata.value = r_value;
            o_mem_wdata.cost  = (r_kind == lct_pkg::KIND_UPSERT_COST) ? r_cost : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
            r_vld   <= 1'b0;
            r_shift <= 1'b0;
        end else begin
            r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind  <= i_kind;
                        r_key   <= i_entry_key;
                        r_value <= i_entry_value;
                        r_cost  <= i_entry_cost;
                        r_rd    <= '0;
                        r_vld   <= 1'b0;
                        r_shift <= 1'b0;
                        if (i_kind <= lct_pkg::KIND_DELETE) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_ovld   <= 1'b1;
                            r_status <= lct_pkg::ST_MISS;
                            r_okey   <= '0;
                            r_ovalue <= '0;
                            r_ocost  <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_vld <= issue;
                    if (issue) begin
                        r_rd  <= r_rd + 1'b1;
                        r_idx <= r_rd[AW-1:0];
                    end
                    r_okey   <= '0;
                    r_ovalue <= '0;
                    r_ocost  <= '0;
                    if (r_shift) begin
                        if (scan_end) begin
                            r_count  <= r_count - 1'b1;
                            r_ovld   <= 1'b1;
                            r_status <= lct_pkg::ST_OK;
                            r_state  <= S_IDLE;
                        end
                    end else if (hit) begin
                        if (r_kind == lct_pkg::KIND_DELETE) begin
                            r_shift <= 1'b1;
                        end else begin
                            r_ovld   <= 1'b1;
                            r_status <= lct_pkg::ST_OK;
                            r_state  <= S_IDLE;
                            case (r_kind)
                                lct_pkg::KIND_LOOKUP_KEY: begin
                                    r_ovalue <= i_mem_rdata.value;
                                    r_ocost  <= i_mem_rdata.cost;
                                end
                                lct_pkg::KIND_LOOKUP_VALUE: begin
                                    r_okey <= i_mem_rdata.key;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end else if (scan_end) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                        case (r_kind)
                            lct_pkg::KIND_LOOKUP_KEY: begin
                                r_status <= lct_pkg::ST_MISS;
                                r_ovalue <= lct_pkg::VALUE_NONE;
                                r_ocost  <= lct_pkg::COST_NONE;
                            end
                            lct_pkg::KIND_LOOKUP_VALUE: begin
                                r_status <= lct_pkg::ST_MISS;
                                r_okey   <= lct_pkg::KEY_NONE;
                            end
                            lct_pkg::KIND_UPSERT_ZERO, lct_pkg::KIND_UPSERT_COST: begin
                                if (full) begin
                                    r_status <= lct_pkg::ST_FULL;
                                end else begin
                                    r_status <= lct_pkg::ST_APPEND;
                                    r_count  <= r_count + 1'b1;
                                end
                            end
                            default: begin
                                r_status <= lct_pkg::ST_MISS;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = scanning;
    assign o_valid     = r_ovld;
    assign o_status    = r_status;
    assign o_out_key   = r_okey;
    assign o_out_value = r_ovalue;
    assign o_out_cost  = r_ocost;

    `LCT_ASSERT(a_count_bound, r_count <= CW'(ENTRIES), "record count above table size")
    `LCT_ASSERT_IMPL(a_write_busy, o_mem_we, scanning, "table write outside an operation")
    `LCT_ASSERT_IMPL(a_write_below_count, o_mem_we, CW'(o_mem_waddr) <= r_count, "write past end")
    `LCT_ASSERT_IMPL(a_append_count, r_ovld && (r_status == lct_pkg::ST_APPEND), r_count == $past(r_count) + 1'b1, "append did not grow the table")
    `LCT_ASSERT_IMPL(a_result_source, r_ovld, $past(scanning) || $past(start), "result without an operation")

endmodule

// ===== rtl/core/link_cost_table_top.sv =====
// Channel   Handshake                    Fields
// command   start in, busy out           i_kind, i_entry_key, i_entry_value, i_entry_cost
// result    o_valid strobe, one cycle    o_status, o_out_key, o_out_value, o_out_cost
//
// A command transfers when start is high and busy is low.
// An operation walks the stored records through the single read port of the record
// memory, one record a cycle; a lookup or update stops early on a hit, a delete walks
// on to close the gap, and an unused kind answers without a scan.
// Reset empties the table at once; record contents need no clearing.
// The result strobe cannot be held off; busy drops in the cycle the result shows.
module link_cost_table_top #(
    parameter int ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_entry_key,
    input  logic [7:0]  i_entry_value,
    input  logic [15:0] i_entry_cost,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_key,
    output logic [7:0]  o_out_value,
    output logic [15:0] o_out_cost
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    lct_pkg::t_rec mem_wdata;
    lct_pkg::t_rec mem_rdata;

    lct_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    lct_seq #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .i_entry_cost  (i_entry_cost),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_value   (o_out_value),
        .o_out_cost    (o_out_cost),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata)
    );

endmodule

// ===== dv/link_cost_table_top_tb.sv =====
module link_cost_table_top_tb;

    localparam int DEPTH       = 32;
    localparam int NUM_ITEMS   = 550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int KEY_POOL    = 48;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_QUERY = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  key;
        logic [7:0]  value;
        logic [15:0] cost;
        int          gap;
    } t_link_cmd;

    typedef struct {
        lct_pkg::t_status status;
        logic [7:0]       key;
        logic [7:0]       value;
        logic [15:0]      cost;
    } t_table_answer;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [2:0]  i_kind        = '0;
    logic [7:0]  i_entry_key   = '0;
    logic [7:0]  i_entry_value = '0;
    logic [15:0] i_entry_cost  = '0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_out_key;
    logic [7:0]  o_out_value;
    logic [15:0] o_out_cost;

    t_link_cmd     command_backlog[$];
    t_table_answer answers_due[$];

    // shadow copy of the table, records kept in insertion order
    lct_pkg::t_rec shadow_rec[DEPTH];
    int            shadow_count = 0;
    logic [7:0]    key_pool[KEY_POOL];
    int            gap_left = 0;
    int            n_errors = 0;
    int            n_cycles = 0;

    link_cost_table_top #(.ENTRIES(DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .i_entry_cost  (i_entry_cost),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_value   (o_out_value),
        .o_out_cost    (o_out_cost)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_table_answer apply_command(logic [2:0] kind, logic [7:0] key,
                                                    logic [7:0] value, logic [15:0] cost);
        t_table_answer ans;
        int            key_idx;
        int            val_idx;
        ans = '{status: lct_pkg::ST_MISS, key: '0, value: '0, cost: '0};
        key_idx = shadow_count;
        val_idx = shadow_count;
        // scan backward so the earliest match wins
        for (int n = shadow_count - 1; n >= 0; n--) begin
            if (shadow_rec[n].key == key)
                key_idx = n;
            if (shadow_rec[n].value == value)
                val_idx = n;
        end
        case (kind)
            lct_pkg::KIND_LOOKUP_KEY: begin
                if (key_idx < shadow_count) begin
                    ans.status = lct_pkg::ST_OK;
                    ans.value  = shadow_rec[key_idx].value;
                    ans.cost   = shadow_rec[key_idx].cost;
                end else begin
                    ans.value = lct_pkg::VALUE_NONE;
                    ans.cost  = lct_pkg::COST_NONE;
                end
            end
            lct_pkg::KIND_LOOKUP_VALUE: begin
                if (val_idx < shadow_count) begin
                    ans.status = lct_pkg::ST_OK;
                    ans.key    = shadow_rec[val_idx].key;
                end else begin
                    ans.key = lct_pkg::KEY_NONE;
                end
            end
            lct_pkg::KIND_UPSERT_ZERO, lct_pkg::KIND_UPSERT_COST: begin
                if (key_idx < shadow_count) begin
                    shadow_rec[key_idx].value = value;
                    shadow_rec[key_idx].cost  = cost;
                    ans.status = lct_pkg::ST_OK;
                end else if (shadow_count >= DEPTH) begin
                    ans.status = lct_pkg::ST_FULL;
                end else begin
                    shadow_rec[shadow_count].key   = key;
                    shadow_rec[shadow_count].value = value;
                    shadow_rec[shadow_count].cost  =
                        (kind == lct_pkg::KIND_UPSERT_COST) ? cost : '0;
                    shadow_count++;
                    ans.status = lct_pkg::ST_APPEND;
                end
            end
            lct_pkg::KIND_DELETE: begin
                if (key_idx < shadow_count) begin
                    // close the gap behind the removed record
                    for (int j = key_idx; j + 1 < shadow_count; j++)
                        shadow_rec[j] = shadow_rec[j + 1];
                    shadow_count--;
                    ans.status = lct_pkg::ST_OK;
                end
            end
            default: ans.status = lct_pkg::ST_MISS;
        endcase
        return ans;
    endfunction

    task automatic add_cmd(logic [2:0] kind, logic [7:0] key, logic [7:0] value,
                           logic [15:0] cost, int gap);
        t_link_cmd c;
        c = '{kind: kind, key: key, value: value, cost: cost, gap: gap};
        command_backlog.push_back(c);
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [2:0] pick_kind(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 40) return lct_pkg::KIND_UPSERT_ZERO;
                if (r < 80) return lct_pkg::KIND_UPSERT_COST;
                if (r < 88) return lct_pkg::KIND_LOOKUP_KEY;
                if (r < 93) return lct_pkg::KIND_LOOKUP_VALUE;
                if (r < 98) return lct_pkg::KIND_DELETE;
            end
            MODE_QUERY: begin
                if (r < 8)  return lct_pkg::KIND_UPSERT_ZERO;
                if (r < 15) return lct_pkg::KIND_UPSERT_COST;
                if (r < 55) return lct_pkg::KIND_LOOKUP_KEY;
                if (r < 85) return lct_pkg::KIND_LOOKUP_VALUE;
                if (r < 95) return lct_pkg::KIND_DELETE;
            end
            default: begin
                if (r < 5)  return lct_pkg::KIND_UPSERT_ZERO;
                if (r < 10) return lct_pkg::KIND_UPSERT_COST;
                if (r < 30) return lct_pkg::KIND_LOOKUP_KEY;
                if (r < 45) return lct_pkg::KIND_LOOKUP_VALUE;
                if (r < 98) return lct_pkg::KIND_DELETE;
            end
        endcase
        return KIND_SPARE_FIRST + 3'($urandom_range(0, KIND_SPARE_LAST - KIND_SPARE_FIRST));
    endfunction

    // driver: hold the command while busy, then advance after the idle gap
    always @(posedge i_clk) begin
        t_link_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                answers_due.push_back(apply_command(i_kind, i_entry_key, i_entry_value,
                                                    i_entry_cost));
            if (start && busy) begin
                // hold
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (command_backlog.size() > 0) begin
                c = command_backlog.pop_front();
                i_kind        <= c.kind;
                i_entry_key   <= c.key;
                i_entry_value <= c.value;
                i_entry_cost  <= c.cost;
                start         <= 1'b1;
                gap_left = c.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result is one transfer
    always @(posedge i_clk) begin
        t_table_answer exp;
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d key=%h value=%h cost=%h",
                         $time, o_status, o_out_key, o_out_value, o_out_cost);
                n_errors++;
            end else begin
                exp = answers_due.pop_front();
                if (o_status !== exp.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp.status,
                             o_status);
                    n_errors++;
                end
                if (o_out_key !== exp.key) begin
                    $display("%0t: out_key expected %h actual %h", $time, exp.key, o_out_key);
                    n_errors++;
                end
                if (o_out_value !== exp.value) begin
                    $display("%0t: out_value expected %h actual %h", $time, exp.value,
                             o_out_value);
                    n_errors++;
                end
                if (o_out_cost !== exp.cost) begin
                    $display("%0t: out_cost expected %h actual %h", $time, exp.cost,
                             o_out_cost);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("link_cost_table_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int     mode;
        int     run_len;
        bit     quiet;
        logic [7:0] k;
        logic [7:0] v;
        logic [15:0] c;

        // empty table: every search misses
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'h00, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_VALUE, 8'h00, 8'h00, 16'h0000, 2);
        add_cmd(lct_pkg::KIND_DELETE,       8'h00, 8'h00, 16'h0000, 0);
        // zero-cost insert drops the given cost; given-cost insert keeps it
        add_cmd(lct_pkg::KIND_UPSERT_ZERO,  8'h00, 8'h00, 16'hFFFF, 0);
        add_cmd(lct_pkg::KIND_UPSERT_COST,  8'hFF, 8'hFF, 16'hFFFF, 1);
        add_cmd(lct_pkg::KIND_UPSERT_COST,  8'h5A, 8'hA5, 16'h8001, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'h00, 8'h00, 16'h0000, 0);
        // a hit whose fields look like a miss
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'hFF, 8'h00, 16'h0000, 5);
        add_cmd(lct_pkg::KIND_LOOKUP_VALUE, 8'h00, 8'hFF, 16'h0000, 0);
        // update through the zero-cost kind still stores the full cost
        add_cmd(lct_pkg::KIND_UPSERT_ZERO,  8'h00, 8'h5A, 16'h1234, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'h00, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_UPSERT_COST,  8'h33, 8'h5A, 16'h7FFF, 0);
        // two records share the value: the earliest one answers
        add_cmd(lct_pkg::KIND_LOOKUP_VALUE, 8'h00, 8'h5A, 16'h0000, 3);
        // delete from the middle, then make sure the neighbors survive
        add_cmd(lct_pkg::KIND_DELETE,       8'hFF, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'hFF, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'h5A, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_VALUE, 8'h00, 8'hA5, 16'h0000, 0);
        // unused kinds change nothing
        add_cmd(KIND_SPARE_FIRST,        8'hFF, 8'hFF, 16'hFFFF, 0);
        add_cmd(KIND_SPARE_FIRST + 3'd1, 8'h00, 8'h00, 16'h0000, 1);
        add_cmd(KIND_SPARE_LAST,         8'hFF, 8'hFF, 16'hFFFF, 0);
        // delete the first and last records, then empty the table
        add_cmd(lct_pkg::KIND_DELETE,       8'h00, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_DELETE,       8'h33, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_VALUE, 8'h00, 8'hA5, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_DELETE,       8'h5A, 8'h00, 16'h0000, 0);
        add_cmd(lct_pkg::KIND_LOOKUP_KEY,   8'h5A, 8'h00, 16'h0000, 0);

        key_pool[0] = 8'h00;
        key_pool[1] = 8'hFF;
        for (int n = 2; n < KEY_POOL; n++)
            key_pool[n] = 8'($urandom_range(0, 255));

        // fill first so the full-table path is reached early, then wander
        mode    = MODE_FILL;
        run_len = 90;
        quiet   = 1'b0;
        while (command_backlog.size() < NUM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                k = 8'($urandom_range(0, 255));
            else
                k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if ($urandom_range(0, 1) == 0)
                v = 8'($urandom_range(0, 15));
            else
                v = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       c = 16'h0000;
                1:       c = 16'hFFFF;
                default: c = 16'($urandom);
            endcase
            add_cmd(pick_kind(mode), k, v, c, pick_gap(quiet));
            run_len--;
            if (run_len == 0) begin
                mode    = $urandom_range(MODE_FILL, MODE_DRAIN);
                run_len = (mode == MODE_FILL) ? $urandom_range(50, 90) : $urandom_range(20, 60);
                quiet   = ($urandom_range(0, 3) == 0);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (command_backlog.size() != 0 || start || answers_due.size() != 0)
            @(negedge i_clk);
        // drain window: catch any stray result
        repeat (DEPTH + 8) @(negedge i_clk);

        if (n_errors == 0)
            $display("link_cost_table_top_tb: PASS");
        else
            $display("link_cost_table_top_tb: FAIL");
        $finish;
    end

endmodule
